/* hdl/mwlsd_pkg.sv */
// shared types and constants of the multi-window loud sound detector
package mwlsd_pkg;

   localparam int NUM_WINDOWS   = 4;
   localparam int LEVEL_BITS    = 23;
   localparam int SECOND_BITS   = 16;
   localparam int BASELINE_BITS = 12;
   localparam int ADDR_BITS     = 5;
   localparam int DATA_BITS     = 32;

   localparam logic [LEVEL_BITS-1:0]    LEVEL_MAX      = {LEVEL_BITS{1'b1}};
   localparam logic [BASELINE_BITS-1:0] BASELINE_RESET = 12'd1749;
   localparam logic [LEVEL_BITS-1:0]    TH_W32_RESET   = 23'd940;
   localparam logic [LEVEL_BITS-1:0]    TH_W128_RESET  = 23'd3100;
   localparam logic [LEVEL_BITS-1:0]    TH_W512_RESET  = 23'd11550;
   localparam logic [LEVEL_BITS-1:0]    TH_W2048_RESET = 23'd43000;

   // register index, taken from paddr word address
   typedef enum logic [2:0] {
      REG_BASELINE     = 3'd0,
      REG_THRESHOLD_W0 = 3'd1,
      REG_THRESHOLD_W1 = 3'd2,
      REG_THRESHOLD_W2 = 3'd3,
      REG_THRESHOLD_W3 = 3'd4
   } csr_reg_type;

   // firing window code
   typedef enum logic [1:0] {
      WIN_SHORT   = 2'd0,
      WIN_MID     = 2'd1,
      WIN_LONG    = 2'd2,
      WIN_LONGEST = 2'd3
   } win_type;

   typedef struct packed {
      logic [BASELINE_BITS-1:0]                 baseline;
      logic [NUM_WINDOWS-1:0][LEVEL_BITS-1:0]   threshold;
   } cfg_type;

endpackage

/* hdl/mwlsd_if.sv */
// handshake channels for sample/tick items and detector results
interface mwlsd_req_if #(
   parameter int SAMPLE_BITS = 12
);
   logic                   valid;
   logic                   ready;
   logic                   kind;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output kind, output sample, input ready);
   modport sink   (input valid, input kind, input sample, output ready);
endinterface

interface mwlsd_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 loud;
   logic [1:0]                           window;
   logic [mwlsd_pkg::SECOND_BITS-1:0]    event_second;
   logic [mwlsd_pkg::LEVEL_BITS-1:0]     level;

   modport source (output valid, output loud, output window, output event_second,
                   output level, input ready);
   modport sink   (input valid, input loud, input window, input event_second,
                   input level, output ready);
endinterface

/* hdl/mwlsd_csr.sv */
// apb register file: baseline and per-window thresholds
module mwlsd_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [mwlsd_pkg::ADDR_BITS-1:0]      paddr,
   input  logic [mwlsd_pkg::DATA_BITS-1:0]      pwdata,
   output logic [mwlsd_pkg::DATA_BITS-1:0]      prdata,
   output logic                                 pready,
   output mwlsd_pkg::cfg_type                   cfg
);

   mwlsd_pkg::cfg_type     cfg_ff;
   mwlsd_pkg::cfg_type     cfg_in;
   mwlsd_pkg::csr_reg_type reg_sel;
   logic                   wr_en;

   assign reg_sel = mwlsd_pkg::csr_reg_type'(paddr[4:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            mwlsd_pkg::REG_BASELINE:
               cfg_in.baseline = pwdata[mwlsd_pkg::BASELINE_BITS-1:0];
            mwlsd_pkg::REG_THRESHOLD_W0:
               cfg_in.threshold[0] = pwdata[mwlsd_pkg::LEVEL_BITS-1:0];
            mwlsd_pkg::REG_THRESHOLD_W1:
               cfg_in.threshold[1] = pwdata[mwlsd_pkg::LEVEL_BITS-1:0];
            mwlsd_pkg::REG_THRESHOLD_W2:
               cfg_in.threshold[2] = pwdata[mwlsd_pkg::LEVEL_BITS-1:0];
            mwlsd_pkg::REG_THRESHOLD_W3:
               cfg_in.threshold[3] = pwdata[mwlsd_pkg::LEVEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         mwlsd_pkg::REG_BASELINE:
            prdata = mwlsd_pkg::DATA_BITS'(cfg_ff.baseline);
         mwlsd_pkg::REG_THRESHOLD_W0:
            prdata = mwlsd_pkg::DATA_BITS'(cfg_ff.threshold[0]);
         mwlsd_pkg::REG_THRESHOLD_W1:
            prdata = mwlsd_pkg::DATA_BITS'(cfg_ff.threshold[1]);
         mwlsd_pkg::REG_THRESHOLD_W2:
            prdata = mwlsd_pkg::DATA_BITS'(cfg_ff.threshold[2]);
         mwlsd_pkg::REG_THRESHOLD_W3:
            prdata = mwlsd_pkg::DATA_BITS'(cfg_ff.threshold[3]);
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.baseline     <= mwlsd_pkg::BASELINE_RESET;
         cfg_ff.threshold[0] <= mwlsd_pkg::TH_W32_RESET;
         cfg_ff.threshold[1] <= mwlsd_pkg::TH_W128_RESET;
         cfg_ff.threshold[2] <= mwlsd_pkg::TH_W512_RESET;
         cfg_ff.threshold[3] <= mwlsd_pkg::TH_W2048_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hdl/mwlsd_window.sv */
// one block-sum accumulator with its window position counter and threshold compare
module mwlsd_window #(
   parameter int WIN_LEN  = 32,
   parameter int DEV_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic                              restart,
   input  logic [DEV_BITS-1:0]               dev,
   input  logic [mwlsd_pkg::LEVEL_BITS-1:0]  threshold,
   output logic                              done,
   output logic                              over,
   output logic [mwlsd_pkg::LEVEL_BITS-1:0]  level
);

   localparam int CNT_BITS = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
   localparam int SUM_RAW  = CNT_BITS + DEV_BITS;
   localparam int SUM_BITS = (SUM_RAW < mwlsd_pkg::LEVEL_BITS) ? SUM_RAW
                                                                : mwlsd_pkg::LEVEL_BITS;
   localparam int ACC_BITS = mwlsd_pkg::LEVEL_BITS + 1;

   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [SUM_BITS-1:0] sum_ff, sum_in;
   logic [ACC_BITS-1:0] acc;

   assign done = (cnt_ff == CNT_BITS'(WIN_LEN - 1));
   assign acc  = ACC_BITS'(sum_ff) + ACC_BITS'(dev);

   // saturate at the level field limit
   assign level = (acc > ACC_BITS'(mwlsd_pkg::LEVEL_MAX)) ? mwlsd_pkg::LEVEL_MAX
                                                          : acc[mwlsd_pkg::LEVEL_BITS-1:0];
   assign over  = (level > threshold);

   always_comb begin
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      if (step) begin
         if (done || restart) begin
            cnt_in = '0;
            sum_in = '0;
         end else begin
            cnt_in = cnt_ff + CNT_BITS'(1);
            sum_in = level[SUM_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sum_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
      end
   end

endmodule

/* hdl/multi_window_loud_sound_detector_top.sv */
// Multi-window loud sound detector. Each sample item gives exactly one result item and each
// one-second tick gives none. One item is accepted per clock cycle unless a sample is held
// in the input register. An item waits in the input register; a sample is worked in one pass
// through the four window accumulators and the winner select, and its result is registered.
// A sample waits in the input register only while the result register holds an untaken
// result; ticks pass through regardless. Configuration is read and written over the APB port.
module multi_window_loud_sound_detector_top #(
   parameter int SHORT_WINDOW   = 32,
   parameter int MID_WINDOW     = 128,
   parameter int LONG_WINDOW    = 512,
   parameter int LONGEST_WINDOW = 2048,
   parameter int SAMPLE_BITS    = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   mwlsd_req_if.sink                         req_ch,
   mwlsd_rsp_if.source                       rsp_ch,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mwlsd_pkg::ADDR_BITS-1:0]   paddr,
   input  logic [mwlsd_pkg::DATA_BITS-1:0]   pwdata,
   output logic [mwlsd_pkg::DATA_BITS-1:0]   prdata,
   output logic                              pready
);

   localparam int DEV_BITS = (SAMPLE_BITS > mwlsd_pkg::BASELINE_BITS) ? SAMPLE_BITS
                                                                      : mwlsd_pkg::BASELINE_BITS;
   localparam int NW = mwlsd_pkg::NUM_WINDOWS;
   localparam int WIN_LENS [NW] = '{SHORT_WINDOW, MID_WINDOW, LONG_WINDOW, LONGEST_WINDOW};

   mwlsd_pkg::cfg_type cfg;

   // input register
   logic                   in_valid_ff, in_valid_in;
   logic                   in_kind_ff,  in_kind_in;
   logic [SAMPLE_BITS-1:0] in_sample_ff, in_sample_in;

   // result register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_loud_ff, rsp_loud_in;
   mwlsd_pkg::win_type                   rsp_window_ff, rsp_window_in;
   logic [mwlsd_pkg::SECOND_BITS-1:0]    rsp_second_ff, rsp_second_in;
   logic [mwlsd_pkg::LEVEL_BITS-1:0]     rsp_level_ff, rsp_level_in;

   logic [mwlsd_pkg::SECOND_BITS-1:0]    seconds_ff, seconds_in;
   logic [mwlsd_pkg::SECOND_BITS-1:0]    last_event_ff, last_event_in;

   logic                                 advance;
   logic                                 step;
   logic                                 tick;
   logic [DEV_BITS-1:0]                  smp_ext, base_ext, dev;
   logic [NW-1:0]                        win_done, win_over, win_hit;
   logic [NW-1:0][mwlsd_pkg::LEVEL_BITS-1:0] win_level;
   logic                                 any_hit;
   logic                                 fire;
   mwlsd_pkg::win_type                   sel_win;
   logic [mwlsd_pkg::LEVEL_BITS-1:0]     sel_level;

   mwlsd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // a sample moves on only when the result register can take its result
   assign advance = in_valid_ff && (in_kind_ff || !rsp_valid_ff || rsp_ch.ready);
   assign step    = advance && !in_kind_ff;
   assign tick    = advance && in_kind_ff;
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_kind_in   = in_kind_ff;
      in_sample_in = in_sample_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in  = 1'b1;
         in_kind_in   = req_ch.kind;
         in_sample_in = req_ch.sample;
      end else if (advance) begin
         in_valid_in  = 1'b0;
      end
   end

   assign smp_ext  = DEV_BITS'(in_sample_ff);
   assign base_ext = DEV_BITS'(cfg.baseline);
   assign dev      = (smp_ext > base_ext) ? (smp_ext - base_ext) : (base_ext - smp_ext);

   for (genvar g = 0; g < NW; g++) begin : g_win
      mwlsd_window #(
         .WIN_LEN  (WIN_LENS[g]),
         .DEV_BITS (DEV_BITS)
      ) u_win (
         .clock     (clock),
         .reset     (reset),
         .step      (step),
         .restart   (win_done[NW-1]),
         .dev       (dev),
         .threshold (cfg.threshold[g]),
         .done      (win_done[g]),
         .over      (win_over[g]),
         .level     (win_level[g])
      );
   end

   assign win_hit = win_done & win_over;
   assign any_hit = |win_hit;

   // shortest completing window over threshold wins
   always_comb begin
      sel_win   = mwlsd_pkg::WIN_SHORT;
      sel_level = win_level[0];
      for (int k = NW - 1; k >= 0; k--) begin
         if (win_hit[k]) begin
            sel_win   = mwlsd_pkg::win_type'(k[1:0]);
            sel_level = win_level[k];
         end
      end
   end

   assign fire = any_hit && (seconds_ff != last_event_ff);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_loud_in   = rsp_loud_ff;
      rsp_window_in = rsp_window_ff;
      rsp_second_in = rsp_second_ff;
      rsp_level_in  = rsp_level_ff;
      last_event_in = last_event_ff;
      seconds_in    = seconds_ff;
      if (tick) begin
         seconds_in = seconds_ff + mwlsd_pkg::SECOND_BITS'(1);
      end
      if (step) begin
         rsp_valid_in = 1'b1;
         if (fire) begin
            rsp_loud_in   = 1'b1;
            rsp_window_in = sel_win;
            rsp_second_in = seconds_ff;
            rsp_level_in  = sel_level;
            last_event_in = seconds_ff;
         end else begin
            rsp_loud_in   = 1'b0;
            rsp_window_in = mwlsd_pkg::WIN_SHORT;
            rsp_second_in = '0;
            rsp_level_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         seconds_ff    <= '0;
         last_event_ff <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         seconds_ff    <= seconds_in;
         last_event_ff <= last_event_in;
      end
   end

   always_ff @(posedge clock) begin
      in_kind_ff    <= in_kind_in;
      in_sample_ff  <= in_sample_in;
      rsp_loud_ff   <= rsp_loud_in;
      rsp_window_ff <= rsp_window_in;
      rsp_second_ff <= rsp_second_in;
      rsp_level_ff  <= rsp_level_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.loud         = rsp_loud_ff;
   assign rsp_ch.window       = rsp_window_ff;
   assign rsp_ch.event_second = rsp_second_ff;
   assign rsp_ch.level        = rsp_level_ff;

   // a reported event is always the latest recorded event second
   a_loud_matches_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_loud_ff |-> rsp_second_ff == last_event_ff)
      else $error("reported event second differs from recorded last event");

   // quiet results carry an all-zero payload
   a_quiet_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_loud_ff |->
         rsp_window_ff == mwlsd_pkg::WIN_SHORT && rsp_second_ff == '0 && rsp_level_ff == '0)
      else $error("quiet result with nonzero payload");

   // a firing sample records its second as the last event and gives a loud result
   a_fire_new_second: assert property (@(posedge clock) disable iff (reset)
      step && fire |=> last_event_ff == $past(seconds_ff) && rsp_valid_ff && rsp_loud_ff)
      else $error("event did not record its second");

   // a loud level lies above the firing window threshold, so it is never zero
   a_loud_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_loud_ff |-> rsp_level_ff != '0)
      else $error("loud result with zero level");

endmodule
